>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the flash command core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CHK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CHK(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

>>> src/fcsm_pkg.sv
// ----------------------------------------------------------------------------
// fcsm_pkg
// Constants and types of the flash command state machine.
// ----------------------------------------------------------------------------
package fcsm_pkg;

    localparam int DEF_BANK_BYTES   = 65536;
    localparam int DEF_NUM_BANKS    = 2;
    localparam int DEF_SECTOR_BYTES = 4096;

    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;
    localparam int CFG_AW = 3;

    localparam logic [CFG_AW-1:0] REG_SIZE_MODE = 3'h0;

    localparam logic [ADDR_W-1:0] ADDR_UNLOCK1 = 16'h5555;
    localparam logic [ADDR_W-1:0] ADDR_UNLOCK2 = 16'h2AAA;

    localparam logic [DATA_W-1:0] CMD_UNLOCK1 = 8'hAA;
    localparam logic [DATA_W-1:0] CMD_UNLOCK2 = 8'h55;
    localparam logic [DATA_W-1:0] CMD_ID      = 8'h90;
    localparam logic [DATA_W-1:0] CMD_ERASE   = 8'h80;
    localparam logic [DATA_W-1:0] CMD_RESET   = 8'hF0;
    localparam logic [DATA_W-1:0] CMD_PROGRAM = 8'hA0;
    localparam logic [DATA_W-1:0] CMD_BANK    = 8'hB0;
    localparam logic [DATA_W-1:0] CMD_SECTOR  = 8'h30;
    localparam logic [DATA_W-1:0] CMD_CHIP    = 8'h10;

    localparam logic [DATA_W-1:0] MFR_ID_64K  = 8'h32;
    localparam logic [DATA_W-1:0] DEV_ID_64K  = 8'h1B;
    localparam logic [DATA_W-1:0] MFR_ID_128K = 8'h62;
    localparam logic [DATA_W-1:0] DEV_ID_128K = 8'h13;
    localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;

    localparam logic ACT_READ = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_EXEC = 3'b100
    } t_seq;

    typedef enum logic [8:0] {
        CS_IDLE         = 9'b000000001,
        CS_UNLOCK1      = 9'b000000010,
        CS_UNLOCK2      = 9'b000000100,
        CS_IDMODE       = 9'b000001000,
        CS_ERASE_SETUP  = 9'b000010000,
        CS_ERASE_UNLCK1 = 9'b000100000,
        CS_ERASE_UNLCK2 = 9'b001000000,
        CS_PROGRAM      = 9'b010000000,
        CS_BANK         = 9'b100000000
    } t_step;

    typedef enum logic [2:0] {
        RM_ARRAY  = 3'b001,
        RM_ID     = 3'b010,
        RM_ERASED = 3'b100
    } t_rmode;

endpackage

>>> src/fcsm_if.sv
// ----------------------------------------------------------------------------
// fcsm_in_if / fcsm_out_if
// Valid/ready channels for bus access words and their result words.
// ----------------------------------------------------------------------------
interface fcsm_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] address;
    logic [7:0]  write_data;

    modport source (output valid, action, address, write_data, input ready);
    modport sink   (input valid, action, address, write_data, output ready);
endinterface

interface fcsm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       store_changed;

    modport source (output valid, read_data, store_changed, input ready);
    modport sink   (input valid, read_data, store_changed, output ready);
endinterface

>>> src/flash_command_state_machine_core.sv
// ----------------------------------------------------------------------------
// flash_command_state_machine_core
// An accepted access word passes through S_LOOK and S_EXEC; its result word is
//   registered when S_EXEC fires, which waits while the output is stalled. A new
//   word is taken only in S_IDLE; an erase then holds ready low during the sweep.
// Reset: synchronous; a clearing pass writes FF over all NUM_BANKS*BANK_BYTES
//   bytes with ready low; config writes still land.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flash_command_state_machine_core
    import fcsm_pkg::*;
#(
    parameter int BANK_BYTES   = DEF_BANK_BYTES,
    parameter int NUM_BANKS    = DEF_NUM_BANKS,
    parameter int SECTOR_BYTES = DEF_SECTOR_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    fcsm_in_if.sink           i_in,
    fcsm_out_if.source        o_out
);

    localparam int STORE_BYTES = BANK_BYTES * NUM_BANKS;
    localparam int SAW         = $clog2(STORE_BYTES);

    t_seq               r_seq;
    t_seq               n_seq;
    t_step              r_step;
    t_step              n_step;
    t_rmode             r_rmode;
    t_rmode             n_rmode;
    logic               r_bank;
    logic               n_bank;
    logic               r_size;
    logic               r_act;
    logic [ADDR_W-1:0]  r_addr;
    logic [DATA_W-1:0]  r_data;
    logic               r_ovalid;
    logic [DATA_W-1:0]  r_ordata;
    logic               r_ochg;
    logic [DATA_W-1:0]  n_rdata;
    logic               n_chg;
    logic               w_busy;
    logic               w_accept;
    logic               w_fire;
    logic               w_wr_en;
    logic               w_erase;
    logic [SAW-1:0]     w_er_first;
    logic [SAW-1:0]     w_er_last;
    logic [ADDR_W-1:0]  w_off;
    logic [31:0]        w_base;
    logic [31:0]        w_sec_start;
    logic [31:0]        w_sec_end;
    logic [SAW-1:0]     w_index;
    logic [DATA_W-1:0]  w_mem_data;

    assign w_off       = r_addr & ADDR_W'(BANK_BYTES - 1);
    assign w_base      = 32'(r_bank) * BANK_BYTES;
    assign w_index     = SAW'(w_base + 32'(w_off));
    assign w_sec_start = 32'(w_off & ~ADDR_W'(SECTOR_BYTES - 1));
    assign w_sec_end   = (w_sec_start + SECTOR_BYTES > BANK_BYTES) ?
                         32'(BANK_BYTES - 1) : w_sec_start + SECTOR_BYTES - 1;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_fire   = (r_seq == S_EXEC) && (!r_ovalid || o_out.ready);

    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            S_IDLE: if (w_accept) n_seq = S_LOOK;
            S_LOOK: n_seq = S_EXEC;
            S_EXEC: if (w_fire) n_seq = S_IDLE;
            default: n_seq = S_IDLE;
        endcase
    end

    always_comb begin
        n_step     = r_step;
        n_rmode    = r_rmode;
        n_bank     = r_bank;
        n_rdata    = '0;
        n_chg      = 1'b0;
        w_wr_en    = 1'b0;
        w_erase    = 1'b0;
        w_er_first = SAW'(w_base + w_sec_start);
        w_er_last  = SAW'(w_base + w_sec_end);
        if (r_act == ACT_READ) begin
            case (r_rmode)
                RM_ARRAY: n_rdata = w_mem_data;
                RM_ID: begin
                    if (r_addr[7:0] == 8'h00) begin
                        n_rdata = r_size ? MFR_ID_128K : MFR_ID_64K;
                    end else if (r_addr[7:0] == 8'h01) begin
                        n_rdata = r_size ? DEV_ID_128K : DEV_ID_64K;
                    end
                end
                RM_ERASED: begin
                    n_rdata = ERASED_BYTE;
                    n_step  = CS_IDLE;
                    n_rmode = RM_ARRAY;
                end
                default: n_rdata = '0;
            endcase
        end else begin
            case (r_step)
                CS_IDLE: begin
                    if (r_addr == ADDR_UNLOCK1 && r_data == CMD_UNLOCK1) n_step = CS_UNLOCK1;
                end
                CS_UNLOCK1: begin
                    n_step = (r_addr == ADDR_UNLOCK2 && r_data == CMD_UNLOCK2) ?
                             CS_UNLOCK2 : CS_IDLE;
                end
                CS_UNLOCK2: begin
                    n_step  = CS_IDLE;
                    n_rmode = RM_ARRAY;
                    if (r_addr == ADDR_UNLOCK1) begin
                        if (r_data == CMD_ID) begin
                            n_step  = CS_IDMODE;
                            n_rmode = RM_ID;
                        end else if (r_data == CMD_ERASE) begin
                            n_step  = CS_ERASE_SETUP;
                            n_rmode = r_rmode;
                        end else if (r_data == CMD_PROGRAM) begin
                            n_step  = CS_PROGRAM;
                            n_rmode = r_rmode;
                        end else if (r_data == CMD_BANK && r_size) begin
                            n_step  = CS_BANK;
                            n_rmode = r_rmode;
                        end
                    end
                end
                CS_ERASE_SETUP: begin
                    if (r_addr == ADDR_UNLOCK1 && r_data == CMD_UNLOCK1) begin
                        n_step = CS_ERASE_UNLCK1;
                    end else begin
                        n_step  = CS_IDLE;
                        n_rmode = RM_ARRAY;
                    end
                end
                CS_ERASE_UNLCK1: begin
                    if (r_addr == ADDR_UNLOCK2 && r_data == CMD_UNLOCK2) begin
                        n_step = CS_ERASE_UNLCK2;
                    end else begin
                        n_step  = CS_IDLE;
                        n_rmode = RM_ARRAY;
                    end
                end
                CS_ERASE_UNLCK2: begin
                    if (r_data == CMD_SECTOR) begin
                        w_erase = 1'b1;
                        n_rmode = RM_ERASED;
                        n_chg   = 1'b1;
                    end else if (r_data == CMD_CHIP) begin
                        w_erase    = 1'b1;
                        w_er_first = '0;
                        w_er_last  = r_size ? SAW'(STORE_BYTES - 1) : SAW'(BANK_BYTES - 1);
                        n_rmode    = RM_ERASED;
                        n_chg      = 1'b1;
                    end else begin
                        n_step  = CS_IDLE;
                        n_rmode = RM_ARRAY;
                    end
                end
                CS_IDMODE: begin
                    n_step  = CS_IDLE;
                    n_rmode = RM_ARRAY;
                    if (r_data != CMD_RESET && r_addr == ADDR_UNLOCK1 &&
                        r_data == CMD_UNLOCK1) begin
                        n_step  = CS_UNLOCK1;
                        n_rmode = r_rmode;
                    end
                end
                CS_PROGRAM: begin
                    w_wr_en = 1'b1;
                    n_chg   = 1'b1;
                    n_step  = CS_IDLE;
                    n_rmode = RM_ARRAY;
                end
                CS_BANK: begin
                    if (r_addr == '0) n_bank = (NUM_BANKS > 1) ? r_data[0] : 1'b0;
                    n_step  = CS_IDLE;
                    n_rmode = RM_ARRAY;
                end
                default: begin
                    n_step  = CS_IDLE;
                    n_rmode = RM_ARRAY;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq    <= S_IDLE;
            r_step   <= CS_IDLE;
            r_rmode  <= RM_ARRAY;
            r_bank   <= 1'b0;
            r_size   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_seq <= n_seq;
            if (w_fire) begin
                r_step   <= n_step;
                r_rmode  <= n_rmode;
                r_bank   <= n_bank;
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (psel && penable && pwrite && paddr[2] == REG_SIZE_MODE[2]) begin
                r_size <= pwdata[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act  <= i_in.action;
            r_addr <= i_in.address;
            r_data <= i_in.write_data;
        end
        if (w_fire) begin
            r_ordata <= n_rdata;
            r_ochg   <= n_chg;
        end
    end

    fcsm_store #(
        .STORE_BYTES (STORE_BYTES)
    ) u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_erase       (w_fire && w_erase),
        .i_erase_first (w_er_first),
        .i_erase_last  (w_er_last),
        .i_wr_en       (w_fire && w_wr_en),
        .i_wr_addr     (w_index),
        .i_wr_data     (r_data),
        .i_rd_addr     (w_index),
        .o_rd_data     (w_mem_data),
        .o_busy        (w_busy)
    );

    assign i_in.ready          = (r_seq == S_IDLE) && !w_busy;
    assign o_out.valid         = r_ovalid;
    assign o_out.read_data     = r_ordata;
    assign o_out.store_changed = r_ochg;
    assign pready              = 1'b1;
    assign prdata              = (paddr[2] == REG_SIZE_MODE[2]) ? {31'd0, r_size} : 32'd0;

    `ASSERT_CHK(a_accept_to_look, i_clk, i_rst_n, w_accept |=> (r_seq == S_LOOK))
    `ASSERT_NEVER(a_ready_while_sweep, i_clk, i_rst_n, i_in.ready && w_busy)
    `ASSERT_NEVER(a_write_word_no_data, i_clk, i_rst_n, o_out.valid && r_ordata != '0 && r_ochg)

endmodule

>>> src/fcsm_store.sv
// ----------------------------------------------------------------------------
// fcsm_store
// Byte store with a registered read port and an erase sweep engine that
// writes FF one byte per cycle over a range; sweeps the whole store after
// reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcsm_store
    import fcsm_pkg::*;
#(
    parameter int STORE_BYTES = DEF_BANK_BYTES * DEF_NUM_BANKS,
    localparam int AW = $clog2(STORE_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_erase,
    input  logic [AW-1:0] i_erase_first,
    input  logic [AW-1:0] i_erase_last,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data,
    output logic          o_busy
);

    logic [7:0]    r_mem [STORE_BYTES];
    logic [7:0]    r_rd_data;
    logic          r_busy;
    logic [AW-1:0] r_ptr;
    logic [AW-1:0] r_last;
    logic          n_busy;
    logic [AW-1:0] n_ptr;
    logic [AW-1:0] n_last;
    logic          w_mem_we;
    logic [AW-1:0] w_mem_addr;
    logic [7:0]    w_mem_data;

    always_comb begin
        n_busy = r_busy;
        n_ptr  = r_ptr;
        n_last = r_last;
        if (r_busy) begin
            if (r_ptr == r_last) begin
                n_busy = 1'b0;
            end else begin
                n_ptr = r_ptr + AW'(1);
            end
        end else if (i_erase) begin
            n_busy = 1'b1;
            n_ptr  = i_erase_first;
            n_last = i_erase_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_ptr  <= '0;
            r_last <= AW'(STORE_BYTES - 1);
        end else begin
            r_busy <= n_busy;
            r_ptr  <= n_ptr;
            r_last <= n_last;
        end
    end

    assign w_mem_we   = r_busy | i_wr_en;
    assign w_mem_addr = r_busy ? r_ptr : i_wr_addr;
    assign w_mem_data = r_busy ? ERASED_BYTE : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

    `ASSERT_CHK(a_sweep_ends_at_last, i_clk, i_rst_n, $fell(r_busy) |-> $past(r_ptr == r_last))
    `ASSERT_NEVER(a_no_write_in_sweep, i_clk, i_rst_n, r_busy && i_wr_en)
    `ASSERT_NEVER(a_no_erase_in_sweep, i_clk, i_rst_n, r_busy && i_erase)

endmodule

>>> verif/fcsm_checker.sv
// ----------------------------------------------------------------------------
// fcsm_checker
// Watches the config port and both word channels of the flash command core.
// Keeps its own copy of the command state, read mode, bank and the whole
// byte store, predicts each result word from every accepted access word and
// compares it field by field against the words the core hands out.
// ----------------------------------------------------------------------------
module fcsm_checker
    import fcsm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [CFG_AW-1:0] i_paddr,
    input  logic [31:0]       i_pwdata,
    fcsm_in_if                i_in_mon,
    fcsm_out_if               i_out_mon,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_BYTES = DEF_BANK_BYTES * DEF_NUM_BANKS;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              store_changed;
    } t_result;

    logic [DATA_W-1:0] flash_mem [STORE_BYTES];
    t_step             cmd_step;
    t_rmode            rd_mode;
    logic              bank_sel;
    logic              size_mode_q;
    t_result           expected_words [$];
    int                word_idx;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        word_idx     = 0;
        cmd_step     = CS_IDLE;
        rd_mode      = RM_ARRAY;
        bank_sel     = 1'b0;
        size_mode_q  = 1'b0;
        foreach (flash_mem[i]) flash_mem[i] = ERASED_BYTE;
    end

    task automatic report_error(input string what, input int got, input int want);
        if (o_fail_count < 100) begin
            $display("ERROR word %0d: %s got %0h expected %0h", word_idx, what, got, want);
        end
        o_fail_count++;
    endtask

    function automatic void go_array();
        cmd_step = CS_IDLE;
        rd_mode  = RM_ARRAY;
    endfunction

    function automatic void fill_erased(input int first, input int count);
        for (int i = first; i < first + count; i++) flash_mem[i] = ERASED_BYTE;
    endfunction

    function automatic t_result predict_access(input logic act, input logic [ADDR_W-1:0] addr,
                                               input logic [DATA_W-1:0] wd);
        t_result r;
        int      start;
        r = '0;
        if (act == ACT_READ) begin
            case (rd_mode)
                RM_ARRAY: r.read_data = flash_mem[{bank_sel, addr}];
                RM_ID: begin
                    if (addr[7:0] == 8'h00) begin
                        r.read_data = size_mode_q ? MFR_ID_128K : MFR_ID_64K;
                    end else if (addr[7:0] == 8'h01) begin
                        r.read_data = size_mode_q ? DEV_ID_128K : DEV_ID_64K;
                    end
                end
                RM_ERASED: begin
                    go_array();
                    r.read_data = ERASED_BYTE;
                end
                default: r.read_data = '0;
            endcase
            return r;
        end
        case (cmd_step)
            CS_IDLE: begin
                if (addr == ADDR_UNLOCK1 && wd == CMD_UNLOCK1) cmd_step = CS_UNLOCK1;
            end
            CS_UNLOCK1: begin
                if (addr == ADDR_UNLOCK2 && wd == CMD_UNLOCK2) cmd_step = CS_UNLOCK2;
                else cmd_step = CS_IDLE;
            end
            CS_UNLOCK2: begin
                if (addr != ADDR_UNLOCK1) begin
                    go_array();
                end else if (wd == CMD_ID) begin
                    cmd_step = CS_IDMODE;
                    rd_mode  = RM_ID;
                end else if (wd == CMD_ERASE) begin
                    cmd_step = CS_ERASE_SETUP;
                end else if (wd == CMD_PROGRAM) begin
                    cmd_step = CS_PROGRAM;
                end else if (wd == CMD_BANK && size_mode_q) begin
                    cmd_step = CS_BANK;
                end else begin
                    go_array();
                end
            end
            CS_ERASE_SETUP: begin
                if (addr == ADDR_UNLOCK1 && wd == CMD_UNLOCK1) cmd_step = CS_ERASE_UNLCK1;
                else go_array();
            end
            CS_ERASE_UNLCK1: begin
                if (addr == ADDR_UNLOCK2 && wd == CMD_UNLOCK2) cmd_step = CS_ERASE_UNLCK2;
                else go_array();
            end
            CS_ERASE_UNLCK2: begin
                // hold the final erase step so a further erase command repeats
                if (wd == CMD_SECTOR) begin
                    start = int'(addr) & ~(DEF_SECTOR_BYTES - 1);
                    fill_erased(int'(bank_sel) * DEF_BANK_BYTES + start, DEF_SECTOR_BYTES);
                    rd_mode         = RM_ERASED;
                    r.store_changed = 1'b1;
                end else if (wd == CMD_CHIP) begin
                    fill_erased(0, size_mode_q ? STORE_BYTES : DEF_BANK_BYTES);
                    rd_mode         = RM_ERASED;
                    r.store_changed = 1'b1;
                end else begin
                    go_array();
                end
            end
            CS_IDMODE: begin
                if (wd == CMD_RESET) go_array();
                else if (addr == ADDR_UNLOCK1 && wd == CMD_UNLOCK1) cmd_step = CS_UNLOCK1;
                else go_array();
            end
            CS_PROGRAM: begin
                flash_mem[{bank_sel, addr}] = wd;
                r.store_changed = 1'b1;
                go_array();
            end
            CS_BANK: begin
                if (addr == '0) bank_sel = wd[0];
                go_array();
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == REG_SIZE_MODE) begin
                size_mode_q = i_pwdata[0];
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                expected_words.push_back(predict_access(i_in_mon.action, i_in_mon.address,
                                                        i_in_mon.write_data));
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.read_data     = i_out_mon.read_data;
                got.store_changed = i_out_mon.store_changed;
                if (expected_words.size() == 0) begin
                    report_error("result word with nothing pending", got.read_data, 0);
                end else begin
                    want = expected_words.pop_front();
                    if (got.read_data !== want.read_data) begin
                        report_error("read_data", got.read_data, want.read_data);
                    end
                    if (got.store_changed !== want.store_changed) begin
                        report_error("store_changed", got.store_changed, want.store_changed);
                    end
                end
                word_idx++;
            end
            o_pending = expected_words.size();
        end
    end

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the flash command core with bus access words: a directed pass over
// the command set, then random unlock sequences with random content mixed
// with noise and broken sequences, over both part sizes and three idling
// patterns. The checker beside the core predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fcsm_pkg::*;

    localparam logic ACT_WRITE   = ~ACT_READ;
    localparam int   CYCLE_LIMIT = 4000000;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [CFG_AW-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    fcsm_in_if  in_bus ();
    fcsm_out_if out_bus ();

    int          fail_count;
    int          pending;
    int          send_idle         = 23;
    int          recv_idle         = 85;
    int          words_sent        = 0;
    int          cycle_count       = 0;
    int          chip_erase_left   = 2;
    int          sector_erase_left = 40;
    int          hot_ptr           = 0;
    logic [15:0] hot_addr [8];

    flash_command_state_machine_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    fcsm_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_in_mon     (in_bus),
        .i_out_mon    (out_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        out_bus.ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_word(input logic act, input logic [15:0] addr, input logic [7:0] wd);
        while ($urandom_range(99) < send_idle) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid      <= 1'b1;
        in_bus.action     <= act;
        in_bus.address    <= addr;
        in_bus.write_data <= wd;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        words_sent++;
    endtask

    task automatic read_word(input logic [15:0] addr);
        send_word(ACT_READ, addr, 8'($urandom()));
    endtask

    task automatic unlock();
        send_word(ACT_WRITE, ADDR_UNLOCK1, CMD_UNLOCK1);
        send_word(ACT_WRITE, ADDR_UNLOCK2, CMD_UNLOCK2);
    endtask

    // drop valid and wait until every result word is back and the core is ready
    task automatic drain();
        in_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || in_bus.ready !== 1'b1);
    endtask

    task automatic cfg_size_mode(input logic mode);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_SIZE_MODE;
        pwdata  <= {31'b0, mode};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [15:0] pick_addr();
        case ($urandom_range(4))
            0: return hot_addr[$urandom_range(7)];
            1: begin
                case ($urandom_range(7))
                    0: return 16'h0000;
                    1: return 16'h0001;
                    2: return 16'hFFFF;
                    3: return ADDR_UNLOCK1;
                    4: return ADDR_UNLOCK2;
                    5: return 16'h0FFF;
                    6: return 16'h1000;
                    default: return 16'h8000;
                endcase
            end
            2: return 16'($urandom_range(511));
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_erase(output logic [7:0] cmd);
        if (chip_erase_left > 0 && $urandom_range(5) == 0) begin
            chip_erase_left--;
            cmd = CMD_CHIP;
        end else if (sector_erase_left > 0) begin
            sector_erase_left--;
            cmd = CMD_SECTOR;
        end else begin
            cmd = CMD_RESET;
        end
        send_word(ACT_WRITE, pick_addr(), cmd);
    endtask

    task automatic run_directed();
        read_word(16'hFFFF);
        unlock();
        send_word(ACT_WRITE, ADDR_UNLOCK1, CMD_PROGRAM);
        send_word(ACT_WRITE, 16'hFFFF, 8'h00);
        read_word(16'hFFFF);
        unlock();
        send_word(ACT_WRITE, ADDR_UNLOCK1, CMD_ID);
        read_word(16'h0000);
        read_word(16'hA501);
        read_word(16'h00FF);
        send_word(ACT_WRITE, 16'h0000, CMD_RESET);
        unlock();
        send_word(ACT_WRITE, ADDR_UNLOCK1, CMD_BANK);
        unlock();
        send_word(ACT_WRITE, ADDR_UNLOCK1, CMD_ERASE);
        unlock();
        send_word(ACT_WRITE, 16'hF123, CMD_SECTOR);
        send_word(ACT_WRITE, 16'h0000, CMD_CHIP);
        read_word(16'hFFFF);
        read_word(16'hFFFF);
    endtask

    task automatic run_traffic(input int target);
        int          kind;
        int          k;
        logic [15:0] a;
        logic [7:0]  d;
        while (words_sent < target) begin
            kind = $urandom_range(99);
            if (kind < 14) begin
                a = pick_addr();
                d = 8'($urandom());
                if (d == CMD_CHIP) d = ~d;
                send_word(1'($urandom_range(1)), a, d);
            end else if (kind < 34) begin
                repeat ($urandom_range(1, 3)) read_word(pick_addr());
            end else if (kind < 56) begin
                unlock();
                send_word(ACT_WRITE, ADDR_UNLOCK1, CMD_PROGRAM);
                a = pick_addr();
                case ($urandom_range(3))
                    0: d = 8'h00;
                    1: d = 8'hFF;
                    default: d = 8'($urandom());
                endcase
                send_word(ACT_WRITE, a, d);
                hot_addr[hot_ptr] = a;
                hot_ptr = (hot_ptr + 1) % 8;
                if ($urandom_range(1) == 1) read_word(a);
            end else if (kind < 66) begin
                unlock();
                send_word(ACT_WRITE, ADDR_UNLOCK1, CMD_ID);
                repeat ($urandom_range(1, 3)) begin
                    a = pick_addr();
                    case ($urandom_range(2))
                        0: a[7:0] = 8'h00;
                        1: a[7:0] = 8'h01;
                        default: ;
                    endcase
                    read_word(a);
                end
                case ($urandom_range(3))
                    0, 1: send_word(ACT_WRITE, pick_addr(), CMD_RESET);
                    2: send_word(ACT_WRITE, ADDR_UNLOCK1, CMD_UNLOCK1);
                    default: send_word(ACT_WRITE, pick_addr(), 8'($urandom()));
                endcase
            end else if (kind < 74) begin
                unlock();
                send_word(ACT_WRITE, ADDR_UNLOCK1, CMD_BANK);
                a = ($urandom_range(4) != 0) ? 16'h0000 : pick_addr();
                send_word(ACT_WRITE, a, 8'($urandom()));
                read_word(pick_addr());
            end else if (kind < 84) begin
                unlock();
                send_word(ACT_WRITE, ADDR_UNLOCK1, CMD_ERASE);
                unlock();
                send_erase(d);
                if (d != CMD_RESET && $urandom_range(2) == 0) send_erase(d);
                if ($urandom_range(3) != 0) read_word(pick_addr());
                else send_word(ACT_WRITE, pick_addr(), CMD_RESET);
            end else begin
                // unlock and command with one corrupted bit in address or data
                k = $urandom_range(2);
                for (int i = 0; i < 3; i++) begin
                    case (i)
                        0: begin
                            a = ADDR_UNLOCK1;
                            d = CMD_UNLOCK1;
                        end
                        1: begin
                            a = ADDR_UNLOCK2;
                            d = CMD_UNLOCK2;
                        end
                        default: begin
                            a = ADDR_UNLOCK1;
                            case ($urandom_range(3))
                                0: d = CMD_ID;
                                1: d = CMD_PROGRAM;
                                2: d = CMD_BANK;
                                default: d = CMD_ERASE;
                            endcase
                        end
                    endcase
                    if (i == k) begin
                        if ($urandom_range(1) == 1) a = a ^ (16'd1 << $urandom_range(15));
                        else d = d ^ (8'd1 << $urandom_range(7));
                    end
                    send_word(ACT_WRITE, a, d);
                end
            end
        end
    endtask

    initial begin
        in_bus.valid      = 1'b0;
        in_bus.action     = ACT_READ;
        in_bus.address    = '0;
        in_bus.write_data = '0;
        out_bus.ready     = 1'b0;
        foreach (hot_addr[i]) hot_addr[i] = 16'($urandom());
        hot_addr[0] = 16'hFFFF;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        cfg_size_mode(1'b0);
        run_directed();
        run_traffic(300);

        drain();
        send_idle = 85;
        recv_idle = 23;
        cfg_size_mode(1'b1);
        run_traffic(580);

        drain();
        send_idle = 0;
        recv_idle = 0;
        cfg_size_mode(1'b0);
        run_traffic(720);
        cfg_size_mode(1'b1);
        run_traffic(860);

        drain();
        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/fcsm_pkg.sv
src/fcsm_if.sv
src/fcsm_store.sv
src/flash_command_state_machine_core.sv
verif/fcsm_checker.sv
verif/tb_top.sv
